/* hdl/lbs_pkg.sv */
// Shared constants, types and helpers for the LED brightness sequencer.
// Used by lbs_cmd_store and led_brightness_sequencer_top; depends on nothing.

package lbs_pkg;

    // Sizing
    localparam int CHANNELS      = 4;
    localparam int FIFO_DEPTH    = 16;
    localparam int DURATION_BITS = 16;
    localparam int SHOWN         = 4;    // level outputs present on the port
    localparam int LEVEL_W       = 10;
    localparam int STORE_DEPTH   = CHANNELS * FIFO_DEPTH;
    localparam int PTR_W         = $clog2(FIFO_DEPTH);
    localparam int CNT_W         = $clog2(FIFO_DEPTH + 1);
    localparam int CH_W          = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);

    localparam logic [LEVEL_W-1:0] PWM_RANGE_RST = LEVEL_W'(100);

    // Input kinds carried in tuser
    localparam logic MODE_ENQ  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // One queued command
    typedef struct packed {
        logic [DURATION_BITS-1:0] dur;
        logic [LEVEL_W-1:0]       level;
    } t_cmd;

    // Write request into the command store
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        t_cmd              data;
    } t_store_wr;

    // Flat slot address of a channel's FIFO entry
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [CH_W-1:0] ch,
                                                    input logic [PTR_W-1:0] ptr);
        slot_addr = ADDR_W'(ch) * ADDR_W'(FIFO_DEPTH) + ADDR_W'(ptr);
    endfunction

    // Ring pointer advance, wraps at FIFO_DEPTH
    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(FIFO_DEPTH - 1)) begin
            next_ptr = '0;
        end else begin
            next_ptr = p + PTR_W'(1);
        end
    endfunction

endpackage

/* hdl/led_brightness_sequencer_top.sv */
// LED brightness sequencer top level: per-channel command FIFOs and tick walk.
// Depends on lbs_pkg and lbs_cmd_store.

// Four LED channels, each with a 16-deep FIFO of (brightness, duration)
// commands kept in a single shared command RAM. An enqueue transfer
// (tuser = 0) appends to the named channel's FIFO, or flags dropped when it
// is full; a tick transfer (tuser = 1) counts every channel down one
// millisecond and pops the next command where time runs out, saturating the
// brightness to pwm_range at the pop. Every input transfer yields one output
// transfer with all levels, the dropped flag and busy_mask after the item.
// An enqueue goes from input transfer straight to result hand-off; a tick
// walks the channels one at a time through the RAM's single read port, a
// read state then an update state per channel. The input is taken again
// once the result is handed to the output register; a result may wait there
// while the next item is worked on. The user must write pwm_range via
// i_cfg_we / i_cfg_wdata only while idle; the block does not enforce this.

module led_brightness_sequencer_top
    import lbs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // led[1:0], brightness[11:2], duration_ms[27:12]
    input  logic        s_axis_tuser,   // mode[0]
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // level_0[9:0], level_1[19:10], level_2[29:20],
                                        // level_3[39:30], dropped[40], busy_mask[44:41]
    // configuration
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_wdata     // pwm_range
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]               r_state, n_state;
    logic [CH_W-1:0]          r_chan;
    logic [LEVEL_W-1:0]       r_pwm_range;
    logic                     r_drop;
    logic [PTR_W-1:0]         r_rptr  [CHANNELS];
    logic [PTR_W-1:0]         r_wptr  [CHANNELS];
    logic [CNT_W-1:0]         r_fill  [CHANNELS];
    logic [DURATION_BITS-1:0] r_rem   [CHANNELS];
    logic [LEVEL_W-1:0]       r_level [CHANNELS];
    logic                     r_out_valid;
    logic [47:0]              r_out_data;

    // input fields
    logic                     in_mode;
    logic [1:0]               in_led;
    logic [LEVEL_W-1:0]       in_bright;
    logic [15:0]              in_dur;
    logic [31:0]              dur_wide;
    logic [CH_W-1:0]          led_ch;
    logic                     led_ok;
    logic                     s_fire;
    logic                     enq_full;

    t_store_wr                store_wr;
    logic [ADDR_W-1:0]        store_rd_addr;
    t_cmd                     store_rd;

    // tick update terms for the channel being walked
    logic [DURATION_BITS-1:0] rem_dec;
    logic [LEVEL_W-1:0]       pop_level;

    logic                     emit_go;
    logic [47:0]              out_word;
    logic [SHOWN-1:0]         busy_vec;

    assign in_mode   = s_axis_tuser;
    assign in_led    = s_axis_tdata[1:0];
    assign in_bright = s_axis_tdata[11:2];
    assign in_dur    = s_axis_tdata[27:12];
    assign dur_wide  = {16'b0, in_dur};
    assign led_ch    = CH_W'(in_led);
    assign led_ok    = (32'(in_led) < CHANNELS);

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign enq_full      = (r_fill[led_ch] == CNT_W'(FIFO_DEPTH));

    // command RAM write on an accepted enqueue with room
    always_comb begin
        store_wr.we         = s_fire && (in_mode == MODE_ENQ) && led_ok && !enq_full;
        store_wr.addr       = slot_addr(led_ch, r_wptr[led_ch]);
        store_wr.data.dur   = dur_wide[DURATION_BITS-1:0];
        store_wr.data.level = in_bright;
    end

    assign store_rd_addr = slot_addr(r_chan, r_rptr[r_chan]);

    lbs_cmd_store u_store (
        .i_clk     (i_clk),
        .i_wr      (store_wr),
        .i_rd_addr (store_rd_addr),
        .o_rd_data (store_rd)
    );

    // countdown and saturation for the walked channel
    assign rem_dec   = (r_rem[r_chan] != '0) ? r_rem[r_chan] - DURATION_BITS'(1) : '0;
    assign pop_level = (store_rd.level > r_pwm_range) ? r_pwm_range : store_rd.level;

    // result hand-off into the output register
    assign emit_go = (r_state == S_EMIT) && (!r_out_valid || m_axis_tready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    n_state = (in_mode == MODE_TICK) ? S_RD : S_EMIT;
                end
            end
            S_RD: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                n_state = (r_chan == CH_W'(CHANNELS - 1)) ? S_EMIT : S_RD;
            end
            S_EMIT: begin
                if (emit_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control and per-channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chan      <= '0;
            r_pwm_range <= PWM_RANGE_RST;
            r_drop      <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_rptr[c]  <= '0;
                r_wptr[c]  <= '0;
                r_fill[c]  <= '0;
                r_rem[c]   <= '0;
                r_level[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_pwm_range <= i_cfg_wdata;
            end
            // enqueue
            if (s_fire) begin
                r_drop <= (in_mode == MODE_ENQ) && led_ok && enq_full;
                if (store_wr.we) begin
                    r_wptr[led_ch] <= next_ptr(r_wptr[led_ch]);
                    r_fill[led_ch] <= r_fill[led_ch] + CNT_W'(1);
                end
            end
            // tick walk, one channel per read/update pair
            if (r_state == S_UPD) begin
                if (rem_dec != '0) begin
                    r_rem[r_chan] <= rem_dec;
                end else if (r_fill[r_chan] == '0) begin
                    r_rem[r_chan]   <= '0;
                    r_level[r_chan] <= '0;
                end else begin
                    r_level[r_chan] <= pop_level;
                    r_rem[r_chan]   <= store_rd.dur;
                    r_rptr[r_chan]  <= next_ptr(r_rptr[r_chan]);
                    r_fill[r_chan]  <= r_fill[r_chan] - CNT_W'(1);
                end
                if (r_chan == CH_W'(CHANNELS - 1)) begin
                    r_chan <= '0;
                end else begin
                    r_chan <= r_chan + CH_W'(1);
                end
            end
        end
    end

    // result word from the state after the item
    for (genvar g = 0; g < SHOWN; g++) begin : g_show
        if (g < CHANNELS) begin : g_live
            assign out_word[g*LEVEL_W +: LEVEL_W] = r_level[g];
            assign busy_vec[g] = (r_rem[g] != '0) || (r_fill[g] != '0);
        end else begin : g_absent
            assign out_word[g*LEVEL_W +: LEVEL_W] = '0;
            assign busy_vec[g] = 1'b0;
        end
    end
    assign out_word[40]    = r_drop;
    assign out_word[44:41] = busy_vec;
    assign out_word[47:45] = '0;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_go) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_out_data <= out_word;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // FIFO fill never passes its depth
    for (genvar a = 0; a < CHANNELS; a++) begin : g_chk
        a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_fill[a] <= CNT_W'(FIFO_DEPTH))
            else $error("channel fill count above FIFO depth");
    end

    // no RAM write while a tick walk reads it
    a_no_wr_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_UPD) |-> !store_wr.we)
        else $error("command store written during tick walk");

    // an enqueue goes straight to result hand-off
    a_enq_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && in_mode == MODE_ENQ) |=> (r_state == S_EMIT))
        else $error("enqueue did not proceed to result");

    // a full channel flags the drop
    a_drop_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && in_mode == MODE_ENQ && led_ok && enq_full) |=> r_drop)
        else $error("drop on full FIFO not flagged");

endmodule

/* hdl/lbs_cmd_store.sv */
// Command store: one synchronous RAM holding every channel's FIFO slots.
// One write port, one read port with a registered read. Uses lbs_pkg.

module lbs_cmd_store
    import lbs_pkg::*;
(
    input  logic              i_clk,
    input  t_store_wr         i_wr,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_cmd              o_rd_data
);

    t_cmd r_mem [STORE_DEPTH];
    t_cmd r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* tb/sv/led_brightness_sequencer_top_test.sv */
// Self-checking testbench for led_brightness_sequencer_top: stream stimulus, own predictor.
// Depends on lbs_pkg and the led_brightness_sequencer_top RTL.
`timescale 1ns / 100ps

module led_brightness_sequencer_top_test;
    import lbs_pkg::*;

    // Channel state as seen on one output transfer
    typedef struct packed {
        logic [3:0]         busy;
        logic               dropped;
        logic [LEVEL_W-1:0] lv3;
        logic [LEVEL_W-1:0] lv2;
        logic [LEVEL_W-1:0] lv1;
        logic [LEVEL_W-1:0] lv0;
    } t_status;

    localparam int DRAIN_GUARD = 2 * CHANNELS + 4;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // led[1:0], brightness[11:2], duration_ms[27:12]
    logic        s_axis_tuser  = 1'b0; // mode[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;         // level_0..level_3[39:0], dropped[40], busy_mask[44:41]
    logic        i_cfg_we      = 1'b0;
    logic [9:0]  i_cfg_wdata   = '0;   // pwm_range

    // Predicted sequencer state
    logic [LEVEL_W-1:0]       pwm_limit;
    t_cmd                     cmd_ram [CHANNELS*FIFO_DEPTH];
    int unsigned              head [CHANNELS];
    int unsigned              tail [CHANNELS];
    int unsigned              queued [CHANNELS];
    logic [DURATION_BITS-1:0] ms_left [CHANNELS];
    logic [LEVEL_W-1:0]       lit [CHANNELS];

    t_status levels_due [$];
    int      mismatch_count = 0;
    int      send_idle_pct  = 0;
    int      recv_idle_pct  = 0;
    int      hold_req       = 0;
    int      hold_left      = 0;

    led_brightness_sequencer_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Apply one accepted item to the predicted state and queue the status it yields
    task automatic step_sequencer(input logic mode, input logic [1:0] led,
                                  input logic [LEVEL_W-1:0] bright,
                                  input logic [DURATION_BITS-1:0] dur);
        t_status st;
        t_cmd    c;
        st = '0;
        if (mode == MODE_TICK) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                if (ms_left[ch] != 0) ms_left[ch] = ms_left[ch] - 1'b1;
                if (ms_left[ch] == 0) begin
                    if (queued[ch] == 0) begin
                        lit[ch] = '0;
                    end else begin
                        c           = cmd_ram[ch*FIFO_DEPTH + head[ch]];
                        lit[ch]     = (c.level > pwm_limit) ? pwm_limit : c.level;
                        ms_left[ch] = c.dur;
                        head[ch]    = (head[ch] + 1) % FIFO_DEPTH;
                        queued[ch]--;
                    end
                end
            end
        end else if (queued[led] >= FIFO_DEPTH) begin
            st.dropped = 1'b1;
        end else begin
            cmd_ram[led*FIFO_DEPTH + tail[led]] = '{dur: dur, level: bright};
            tail[led] = (tail[led] + 1) % FIFO_DEPTH;
            queued[led]++;
        end
        st.lv0 = lit[0];
        st.lv1 = lit[1];
        st.lv2 = lit[2];
        st.lv3 = lit[3];
        for (int ch = 0; ch < CHANNELS; ch++)
            st.busy[ch] = (ms_left[ch] != 0) || (queued[ch] != 0);
        levels_due.push_back(st);
    endtask

    // Offer one item after a random gap and hold it until the transfer
    task automatic send_item(input logic mode, input logic [1:0] led,
                             input logic [LEVEL_W-1:0] bright,
                             input logic [DURATION_BITS-1:0] dur);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {4'b0, dur, bright, led};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        step_sequencer(mode, led, bright, dur);
    endtask

    // Stop offering and wait until every pending status has arrived
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (levels_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GUARD) @(posedge i_clk);
    endtask

    task automatic set_pwm_limit(input logic [LEVEL_W-1:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        pwm_limit = v;
    endtask

    function automatic logic [LEVEL_W-1:0] pick_level();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return LEVEL_W'($urandom_range(0, 1023));
    endfunction

    // Mostly short holds so FIFOs keep cycling; long ones only when asked
    function automatic logic [DURATION_BITS-1:0] pick_duration(input bit long_ok);
        int r;
        r = $urandom_range(0, 99);
        if (long_ok && r < 4) return DURATION_BITS'($urandom_range(0, 65535));
        if (r < 60) return DURATION_BITS'($urandom_range(0, 3));
        if (r < 90) return DURATION_BITS'($urandom_range(4, 20));
        return DURATION_BITS'($urandom_range(21, 200));
    endfunction

    task automatic send_random(input int tick_pct, input bit long_ok);
        if ($urandom_range(0, 99) < tick_pct)
            send_item(MODE_TICK, 2'($urandom_range(0, 3)),
                      LEVEL_W'($urandom_range(0, 1023)),
                      DURATION_BITS'($urandom_range(0, 65535)));
        else
            send_item(MODE_ENQ, 2'($urandom_range(0, 3)), pick_level(),
                      pick_duration(long_ok));
    endtask

    // Empty tick, saturation, zero duration, late start on idle channel, full FIFO
    task automatic test_directed;
        send_item(MODE_TICK, 2'd0, '0, '0);
        send_item(MODE_ENQ, 2'd0, 10'd1023, 16'd2);
        send_item(MODE_ENQ, 2'd1, 10'd0, 16'd0);
        send_item(MODE_ENQ, 2'd2, 10'd100, 16'd3);
        send_item(MODE_ENQ, 2'd3, 10'd101, 16'd1);
        repeat (3) send_item(MODE_TICK, 2'd3, 10'd1023, 16'hFFFF);
        // sixteen fill channel one, the seventeenth is dropped
        for (int k = 0; k <= FIFO_DEPTH; k++)
            send_item(MODE_ENQ, 2'd1, LEVEL_W'(k * 60), 16'd0);
    endtask

    task automatic test_random_traffic(input logic [LEVEL_W-1:0] limit, input int n_items,
                                       input int tick_pct, input bit long_ok);
        set_pwm_limit(limit);
        repeat (n_items) send_random(tick_pct, long_ok);
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    task automatic test_backpressure;
        int saved_idle;
        drain();
        saved_idle    = send_idle_pct;
        send_idle_pct = 0;
        hold_req      = 300;
        repeat (40) send_random(40, 1'b0);
        send_idle_pct = saved_idle;
    endtask

    // Long holds exercise the upper duration bits
    task automatic test_long_hold;
        send_item(MODE_ENQ, 2'd0, 10'd1023, 16'hFFFF);
        send_item(MODE_ENQ, 2'd1, 10'd512, 16'hAAAA);
        send_item(MODE_ENQ, 2'd2, 10'd341, 16'h5555);
        send_item(MODE_ENQ, 2'd3, 10'd0, 16'h8001);
        repeat (12) send_item(MODE_TICK, 2'd0, '0, '0);
    endtask

    // Receiver ready, with a counted hold-off on request
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Compare each output transfer with the oldest pending status
    always @(posedge i_clk) begin : check_status
        t_status seen;
        t_status want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen = m_axis_tdata[44:0];
            if (levels_due.size() == 0) begin
                if (mismatch_count < 10)
                    $display("%0t: output transfer with nothing pending: %h", $realtime, seen);
                mismatch_count++;
            end else begin
                want = levels_due.pop_front();
                if (seen !== want) begin
                    if (mismatch_count < 10)
                        $display({"%0t: exp lv %0d %0d %0d %0d drop %b busy %b, ",
                                  "got lv %0d %0d %0d %0d drop %b busy %b"},
                                 $realtime, want.lv0, want.lv1, want.lv2, want.lv3,
                                 want.dropped, want.busy, seen.lv0, seen.lv1, seen.lv2,
                                 seen.lv3, seen.dropped, seen.busy);
                    mismatch_count++;
                end
            end
        end
    end

    // Timeout
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        pwm_limit = PWM_RANGE_RST;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            head[ch]    = 0;
            tail[ch]    = 0;
            queued[ch]  = 0;
            ms_left[ch] = '0;
            lit[ch]     = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 34;
        recv_idle_pct = 85;
        test_directed();
        test_random_traffic(10'd1, 100, 50, 1'b0);
        test_random_traffic(10'd1023, 100, 30, 1'b0);

        send_idle_pct = 85;
        recv_idle_pct = 34;
        test_backpressure();
        test_random_traffic(LEVEL_W'($urandom_range(1, 1023)), 130, 50, 1'b0);
        test_random_traffic(10'd100, 130, 70, 1'b0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(10'd1023, 160, 45, 1'b0);
        test_random_traffic(LEVEL_W'($urandom_range(1, 1023)), 150, 55, 1'b1);
        test_long_hold();

        drain();
        if (mismatch_count == 0 && levels_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/lbs_pkg.sv
hdl/lbs_cmd_store.sv
hdl/led_brightness_sequencer_top.sv
tb/sv/led_brightness_sequencer_top_test.sv
